FILE: rtl/qlm_pkg.sv
package qlm_pkg;

   // requester id width, fixed by the request format
   localparam int ID_W = 4;

   // default number of requesters
   localparam int REQUESTERS_DEFAULT = 16;

   // operation codes
   localparam logic CMD_ACQUIRE = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   typedef logic [ID_W-1:0] id_type;

   // write command into the successor id memory
   typedef struct packed {
      logic   en;
      id_type addr;
      id_type data;
   } link_wr_type;

   // one response item
   typedef struct packed {
      logic   granted_now;
      logic   handoff_valid;
      id_type handoff_id;
      logic   error;
   } rsp_type;

endpackage

FILE: rtl/qlm_link_ram.sv
module qlm_link_ram #(
   parameter int DEPTH = qlm_pkg::REQUESTERS_DEFAULT
) (
   input  logic                 clock,
   input  qlm_pkg::link_wr_type wr,
   input  logic                 rd_en,
   input  qlm_pkg::id_type      rd_addr,
   output qlm_pkg::id_type      rd_data
);

   localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   qlm_pkg::id_type link_mem [DEPTH];
   qlm_pkg::id_type rd_data_ff;

   // single write port, successor id of the given requester
   always_ff @(posedge clock) begin
      if (wr.en) begin
         link_mem[IdxW'(wr.addr)] <= wr.data;
      end
   end

   // registered read port, a write to the same entry at the same edge is passed through
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr.en && (wr.addr == rd_addr)) begin
            rd_data_ff <= wr.data;
         end else begin
            rd_data_ff <= link_mem[IdxW'(rd_addr)];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/qlm_lock_ctrl.sv
module qlm_lock_ctrl #(
   parameter int REQUESTERS = qlm_pkg::REQUESTERS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 go,
   input  logic                 cmd,
   input  qlm_pkg::id_type      requester,
   input  qlm_pkg::id_type      link_rd,
   output qlm_pkg::link_wr_type link_wr,
   output logic                 rsp_valid,
   output qlm_pkg::rsp_type     rsp
);

   localparam int IdxW = (REQUESTERS > 1) ? $clog2(REQUESTERS) : 1;

   logic                  holder_valid_ff, holder_valid_in;
   qlm_pkg::id_type       holder_id_ff, holder_id_in;
   logic                  tail_valid_ff, tail_valid_in;
   qlm_pkg::id_type       tail_id_ff, tail_id_in;
   logic [REQUESTERS-1:0] queued_ff, queued_in;
   logic [REQUESTERS-1:0] succ_valid_ff, succ_valid_in;
   logic                  rsp_valid_ff;
   qlm_pkg::rsp_type      rsp_ff, rsp_in;
   logic                  in_range;
   logic [IdxW-1:0]       req_idx;
   logic [IdxW-1:0]       tail_idx;

   assign in_range = (32'(requester) < REQUESTERS);
   assign req_idx  = IdxW'(requester);
   assign tail_idx = IdxW'(tail_id_ff);

   // decide the operation and the new queue state
   always_comb begin
      holder_valid_in = holder_valid_ff;
      holder_id_in    = holder_id_ff;
      tail_valid_in   = tail_valid_ff;
      tail_id_in      = tail_id_ff;
      queued_in       = queued_ff;
      succ_valid_in   = succ_valid_ff;
      link_wr         = '0;
      rsp_in          = '0;
      if (go) begin
         if (!in_range) begin
            rsp_in.error = 1'b1;
         end else if (cmd == qlm_pkg::CMD_ACQUIRE) begin
            if (queued_ff[req_idx]) begin
               rsp_in.error = 1'b1;
            end else begin
               queued_in[req_idx]     = 1'b1;
               succ_valid_in[req_idx] = 1'b0;
               if (tail_valid_ff) begin
                  // link behind the current tail and wait
                  succ_valid_in[tail_idx] = 1'b1;
                  link_wr.en   = 1'b1;
                  link_wr.addr = tail_id_ff;
                  link_wr.data = requester;
                  tail_id_in   = requester;
               end else begin
                  // queue empty: grant at once
                  tail_valid_in      = 1'b1;
                  tail_id_in         = requester;
                  holder_valid_in    = 1'b1;
                  holder_id_in       = requester;
                  rsp_in.granted_now = 1'b1;
               end
            end
         end else begin
            if (!holder_valid_ff || (holder_id_ff != requester)) begin
               rsp_in.error = 1'b1;
            end else begin
               queued_in[req_idx]     = 1'b0;
               succ_valid_in[req_idx] = 1'b0;
               if (succ_valid_ff[req_idx]) begin
                  // hand the lock to the successor
                  holder_id_in         = link_rd;
                  rsp_in.handoff_valid = 1'b1;
                  rsp_in.handoff_id    = link_rd;
               end else begin
                  // holder was the tail: queue becomes empty
                  holder_valid_in = 1'b0;
                  holder_id_in    = '0;
                  tail_valid_in   = 1'b0;
                  tail_id_in      = '0;
               end
            end
         end
      end
   end

   // queue state
   always_ff @(posedge clock) begin
      if (reset) begin
         holder_valid_ff <= 1'b0;
         holder_id_ff    <= '0;
         tail_valid_ff   <= 1'b0;
         tail_id_ff      <= '0;
         queued_ff       <= '0;
         succ_valid_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         holder_valid_ff <= holder_valid_in;
         holder_id_ff    <= holder_id_in;
         tail_valid_ff   <= tail_valid_in;
         tail_id_ff      <= tail_id_in;
         queued_ff       <= queued_in;
         succ_valid_ff   <= succ_valid_in;
         rsp_valid_ff    <= go;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

FILE: rtl/queue_lock_manager.sv
// queue_lock_manager: hardware fifo lock with a linked waiting queue
//
// request channel: raise start with req_cmd (acquire or release) and
// req_requester; the item is taken on a rising edge with start high and
// busy low. busy stays high for one cycle while the item is worked on.
// response channel: rsp_strobe is high for exactly one cycle, the cycle
// after the work cycle, with rsp_granted_now, rsp_handoff_valid,
// rsp_handoff_id and rsp_error. the receiver cannot stall the response.
// no new item is taken while busy is high: the successor id memory needs a
// read-modify-write (read as the item is taken, then decide and write in the
// work cycle); a write and a read of one entry at one edge are forwarded.
// a new item may be taken in the same cycle a response is shown.
// reset (synchronous) frees the lock, empties the queue and clears all
// queued and successor-valid flags; the successor id memory itself is not
// cleared, since an id is used only after it has been written. no clearing
// pass is needed, items are accepted in the first cycle after reset.
module queue_lock_manager #(
   parameter int REQUESTERS = qlm_pkg::REQUESTERS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_cmd,
   input  logic [qlm_pkg::ID_W-1:0] req_requester,
   output logic                 rsp_strobe,
   output logic                 rsp_granted_now,
   output logic                 rsp_handoff_valid,
   output logic [qlm_pkg::ID_W-1:0] rsp_handoff_id,
   output logic                 rsp_error
);

   logic                 busy_ff;
   logic                 cmd_ff;
   qlm_pkg::id_type      requester_ff;
   logic                 accept;
   qlm_pkg::link_wr_type link_wr;
   qlm_pkg::id_type      link_rd;
   qlm_pkg::rsp_type     rsp;

   assign accept = start && !busy_ff;

   // capture the item while its successor id is read
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff       <= req_cmd;
         requester_ff <= req_requester;
      end
   end

   qlm_link_ram #(
      .DEPTH(REQUESTERS)
   ) u_link_ram (
      .clock   (clock),
      .wr      (link_wr),
      .rd_en   (accept),
      .rd_addr (req_requester),
      .rd_data (link_rd)
   );

   qlm_lock_ctrl #(
      .REQUESTERS(REQUESTERS)
   ) u_lock_ctrl (
      .clock     (clock),
      .reset     (reset),
      .go        (busy_ff),
      .cmd       (cmd_ff),
      .requester (requester_ff),
      .link_rd   (link_rd),
      .link_wr   (link_wr),
      .rsp_valid (rsp_strobe),
      .rsp       (rsp)
   );

   assign busy              = busy_ff;
   assign rsp_granted_now   = rsp.granted_now;
   assign rsp_handoff_valid = rsp.handoff_valid;
   assign rsp_handoff_id    = rsp.handoff_id;
   assign rsp_error         = rsp.error;

   // each taken item is worked on for exactly one cycle, then answered
   assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> (rsp_strobe && !busy_ff))
      else $error("item not answered one cycle after its work cycle");

   // a response only follows a work cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy_ff))
      else $error("response without a taken item");

   // a rejected item carries no grant and no handoff
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_error) |->
         (!rsp_granted_now && !rsp_handoff_valid && (rsp_handoff_id == '0)))
      else $error("error response with grant or handoff");

   // the memory is written only during a work cycle
   assert property (@(posedge clock) disable iff (reset)
      link_wr.en |-> (busy_ff && (cmd_ff == qlm_pkg::CMD_ACQUIRE)))
      else $error("successor write outside an acquire");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

// shadow of the lock queue plus the responses still owed by the block
class lock_tracker;
   bit               holder_valid;
   qlm_pkg::id_type  holder_id;
   bit               tail_valid;
   qlm_pkg::id_type  tail_id;
   bit               link_valid [qlm_pkg::REQUESTERS_DEFAULT];
   qlm_pkg::id_type  link_id [qlm_pkg::REQUESTERS_DEFAULT];
   bit               queued [qlm_pkg::REQUESTERS_DEFAULT];
   qlm_pkg::rsp_type owed_rsp [$];
   int unsigned      fails;

   function new();
      holder_valid = 0;
      holder_id    = '0;
      tail_valid   = 0;
      tail_id      = '0;
      fails        = 0;
      foreach (queued[i]) begin
         queued[i]     = 0;
         link_valid[i] = 0;
         link_id[i]    = '0;
      end
   endfunction

   function int unsigned depth();
      int unsigned n;
      n = 0;
      foreach (queued[i]) n += queued[i];
      return n;
   endfunction

   // work out the response of one accepted item and advance the queue
   function void take_request(logic op, qlm_pkg::id_type who);
      qlm_pkg::rsp_type r;
      r = '0;
      if (op == qlm_pkg::CMD_ACQUIRE) begin
         if (queued[who]) begin
            r.error = 1'b1;
         end else begin
            queued[who]     = 1;
            link_valid[who] = 0;
            if (tail_valid) begin
               // link behind the current tail and wait
               link_valid[tail_id] = 1;
               link_id[tail_id]    = who;
               tail_id             = who;
            end else begin
               tail_valid      = 1;
               tail_id         = who;
               holder_valid    = 1;
               holder_id       = who;
               r.granted_now   = 1'b1;
            end
         end
      end else begin
         if (!holder_valid || holder_id != who) begin
            r.error = 1'b1;
         end else begin
            queued[who] = 0;
            if (link_valid[who]) begin
               // hand over to the successor
               holder_id       = link_id[who];
               r.handoff_valid = 1'b1;
               r.handoff_id    = link_id[who];
            end else begin
               holder_valid = 0;
               holder_id    = '0;
               tail_valid   = 0;
               tail_id      = '0;
            end
            link_valid[who] = 0;
         end
      end
      owed_rsp.push_back(r);
   endfunction

   function void compare_field(string what, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         fails++;
      end
   endfunction

   // match one response against the oldest owed one
   function void match_response(qlm_pkg::rsp_type got);
      qlm_pkg::rsp_type want;
      if (owed_rsp.size() == 0) begin
         $display("%0t: unexpected response, expected none, actual %h", $time, got);
         fails++;
      end else begin
         want = owed_rsp.pop_front();
         compare_field("granted_now", want.granted_now, got.granted_now);
         compare_field("handoff_valid", want.handoff_valid, got.handoff_valid);
         compare_field("handoff_id", want.handoff_id, got.handoff_id);
         compare_field("error", want.error, got.error);
      end
   endfunction
endclass

module tb_top;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned RANDOM_ITEMS = 1650;

   logic            clock;
   logic            reset;
   logic            start;
   logic            busy;
   logic            req_cmd;
   qlm_pkg::id_type req_requester;
   logic            rsp_strobe;
   logic            rsp_granted_now;
   logic            rsp_handoff_valid;
   qlm_pkg::id_type rsp_handoff_id;
   logic            rsp_error;
   int unsigned     cycles;
   lock_tracker     lock_q;

   queue_lock_manager i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_requester     (req_requester),
      .rsp_strobe        (rsp_strobe),
      .rsp_granted_now   (rsp_granted_now),
      .rsp_handoff_valid (rsp_handoff_valid),
      .rsp_handoff_id    (rsp_handoff_id),
      .rsp_error         (rsp_error)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // watchdog
   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // monitor: note accepted items, check responses
   always @(posedge clock) begin
      qlm_pkg::rsp_type seen;
      if (!reset) begin
         if (start && !busy) lock_q.take_request(req_cmd, req_requester);
         if (rsp_strobe) begin
            seen = {rsp_granted_now, rsp_handoff_valid, rsp_handoff_id, rsp_error};
            lock_q.match_response(seen);
         end
      end
   end

   // present one item and hold it until taken
   task automatic send_item(input logic op, input qlm_pkg::id_type who);
      @(negedge clock);
      start         <= 1'b1;
      req_cmd       <= op;
      req_requester <= who;
      do @(posedge clock); while (busy);
   endtask

   // sender idle, with start low and junk on the fields
   task automatic hold_off(input int unsigned n);
      @(negedge clock);
      start         <= 1'b0;
      req_cmd       <= 1'($urandom);
      req_requester <= qlm_pkg::id_type'($urandom);
      repeat (n - 1) @(negedge clock);
   endtask

   // stop sending until every owed response has come back
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (lock_q.owed_rsp.size() != 0) @(posedge clock);
   endtask

   // mostly legal traffic steered by queue depth, some noise
   task automatic pick_item(output logic op, output qlm_pkg::id_type who);
      int unsigned     n;
      qlm_pkg::id_type cand;
      n = lock_q.depth();
      if ($urandom_range(99) < 15) begin
         op  = 1'($urandom);
         who = qlm_pkg::id_type'($urandom);
      end else if (lock_q.holder_valid && (n == qlm_pkg::REQUESTERS_DEFAULT
                   || $urandom_range(99) < n * 6 + 10)) begin
         op  = qlm_pkg::CMD_RELEASE;
         who = lock_q.holder_id;
      end else begin
         do cand = qlm_pkg::id_type'($urandom); while (lock_q.queued[cand]);
         op  = qlm_pkg::CMD_ACQUIRE;
         who = cand;
      end
   endtask

   initial begin
      logic            op;
      qlm_pkg::id_type who;
      bit              may_idle;
      lock_q        = new();
      reset         = 1'b1;
      start         = 1'b0;
      req_cmd       = qlm_pkg::CMD_ACQUIRE;
      req_requester = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: free lock, grant, wait, both illegal cases, handoff, empty
      send_item(qlm_pkg::CMD_RELEASE, 4'd3);
      send_item(qlm_pkg::CMD_ACQUIRE, 4'd0);
      send_item(qlm_pkg::CMD_ACQUIRE, 4'd15);
      send_item(qlm_pkg::CMD_ACQUIRE, 4'd0);
      send_item(qlm_pkg::CMD_RELEASE, 4'd15);
      send_item(qlm_pkg::CMD_RELEASE, 4'd0);
      send_item(qlm_pkg::CMD_ACQUIRE, 4'd7);
      send_item(qlm_pkg::CMD_RELEASE, 4'd15);
      send_item(qlm_pkg::CMD_RELEASE, 4'd7);
      send_item(qlm_pkg::CMD_RELEASE, 4'd7);
      // directed: long queue then partial unwind
      for (int i = 15; i >= 4; i--) send_item(qlm_pkg::CMD_ACQUIRE, qlm_pkg::id_type'(i));
      send_item(qlm_pkg::CMD_RELEASE, 4'd15);
      send_item(qlm_pkg::CMD_RELEASE, 4'd14);
      send_item(qlm_pkg::CMD_ACQUIRE, 4'd15);
      drain();

      // random traffic, one stretch with no idling
      for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
         pick_item(op, who);
         send_item(op, who);
         may_idle = !(i >= 600 && i < 900);
         if (may_idle && $urandom_range(99) < 27) hold_off($urandom_range(1, 4));
         if (i == 1000) drain();
      end

      // wind down
      drain();
      repeat (5) @(posedge clock);
      if (lock_q.owed_rsp.size() != 0) lock_q.fails++;
      if (lock_q.fails == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
